// ===== sv/lpl_pkg.sv =====
// Shared types, constants and helpers for the lookahead peak limiter.
// No dependencies; every other file imports this package.
package lpl_pkg;

	localparam int DELAY_DEPTH = 256;
	localparam int ADDR_W      = $clog2(DELAY_DEPTH);
	localparam int CHANNELS    = 2;
	localparam int SAMPLE_W    = 24;
	localparam int GAIN_W      = 17;
	localparam int COEFF_W     = 16;
	localparam int LEN_W       = 8;
	localparam int MEM_W       = CHANNELS * SAMPLE_W;
	localparam int PADDR_W     = 4;
	localparam int PDATA_W     = 32;
	localparam int DIV_STEPS   = 16;
	localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);
	localparam int PROD_W      = 43;

	localparam logic [GAIN_W-1:0]   UNITY_GAIN  = GAIN_W'(65536);
	localparam logic [SAMPLE_W-1:0] FULL_SCALE  = SAMPLE_W'(8388608);
	localparam logic                RST_ENABLE  = 1'b1;
	localparam logic [COEFF_W-1:0]  RST_COEFF   = COEFF_W'(65519);
	localparam logic [LEN_W-1:0]    RST_LENGTH  = LEN_W'(96);

	typedef enum logic [1:0] {
		REG_ENABLE = 2'd0,
		REG_COEFF  = 2'd1,
		REG_LENGTH = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_left;
		logic signed [SAMPLE_W-1:0] sample_right;
		logic        [SAMPLE_W-1:0] ceiling_level;
	} lpl_in_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] out_left;
		logic signed [SAMPLE_W-1:0] out_right;
		logic        [GAIN_W-1:0]   applied_gain;
	} lpl_out_t;

	typedef struct packed {
		logic               enable;
		logic [COEFF_W-1:0] coeff;
		logic [LEN_W-1:0]   length;
	} lpl_cfg_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [MEM_W-1:0]  wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} lpl_mem_req_t;

	typedef struct packed {
		logic                start;
		logic [SAMPLE_W-1:0] dividend;
		logic [SAMPLE_W-1:0] divisor;
	} lpl_div_req_t;

	typedef struct packed {
		logic                 done;
		logic [DIV_STEPS-1:0] quotient;
	} lpl_div_rsp_t;

	// Round half up, then clamp to +/- ceiling and to the 24-bit range.
	function automatic logic signed [SAMPLE_W-1:0] scale_clamp(
		input logic signed [PROD_W-1:0] p,
		input logic        [SAMPLE_W-1:0] ceil_v
	);
		logic signed [PROD_W-1:0]     biased;
		logic signed [SAMPLE_W+2:0]   r;
		logic signed [SAMPLE_W+2:0]   cs;
		logic signed [SAMPLE_W+2:0]   top;
		logic signed [SAMPLE_W+2:0]   bot;
		biased = p + PROD_W'(32768);
		r      = biased[PROD_W-1:16];
		cs     = $signed({3'b000, ceil_v});
		top    = $signed({3'b000, FULL_SCALE}) - (SAMPLE_W+3)'(1);
		bot    = -$signed({3'b000, FULL_SCALE});
		if (r > cs)
			r = cs;
		if (r < -cs)
			r = -cs;
		if (r > top)
			r = top;
		if (r < bot)
			r = bot;
		return r[SAMPLE_W-1:0];
	endfunction

endpackage

// ===== sv/lpl_frame_if.sv =====
// Input frame channel: valid/ready handshake carrying one stereo word.
// Depends on lpl_pkg.
interface lpl_frame_if import lpl_pkg::*; ();
	logic    valid;
	logic    ready;
	lpl_in_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/lpl_result_if.sv =====
// Result channel: valid/ready handshake carrying scaled samples and gain.
// Depends on lpl_pkg.
interface lpl_result_if import lpl_pkg::*; ();
	logic     valid;
	logic     ready;
	lpl_out_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/lpl_regs.sv =====
// APB-style configuration registers: enable, release coefficient, lookahead.
// Depends on lpl_pkg.
module lpl_regs import lpl_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output lpl_cfg_t           cfg
);

	lpl_cfg_t cfg_q;
	logic     wr;
	reg_idx_t idx;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign idx    = reg_idx_t'(paddr[3:2]);
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable <= RST_ENABLE;
			cfg_q.coeff  <= RST_COEFF;
			cfg_q.length <= RST_LENGTH;
		end else if (wr) begin
			case (idx)
				REG_ENABLE: cfg_q.enable <= pwdata[0];
				REG_COEFF:  cfg_q.coeff  <= pwdata[COEFF_W-1:0];
				REG_LENGTH: cfg_q.length <= pwdata[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_ENABLE: prdata = PDATA_W'(cfg_q.enable);
			REG_COEFF:  prdata = PDATA_W'(cfg_q.coeff);
			REG_LENGTH: prdata = PDATA_W'(cfg_q.length);
			default:    prdata = '0;
		endcase
	end

endmodule

// ===== sv/lpl_dmem.sv =====
// Stereo delay ring: one write port, one read port, registered read data.
// Depends on lpl_pkg.
module lpl_dmem import lpl_pkg::*; (
	input  logic             clk,
	input  lpl_mem_req_t     req,
	output logic [MEM_W-1:0] rdata
);

	logic [MEM_W-1:0] mem_q [DELAY_DEPTH];
	logic [MEM_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.we)
			mem_q[req.waddr] <= req.wdata;
		if (req.re)
			rdata_q <= mem_q[req.raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/lpl_div.sv =====
// Restoring divider, one quotient bit per cycle: ceiling * 2^16 / peak.
// Depends on lpl_pkg; needs dividend below divisor so the quotient fits 16 bits.
module lpl_div import lpl_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  lpl_div_req_t req,
	output lpl_div_rsp_t rsp
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [SAMPLE_W-1:0]  rem_q;
	logic [SAMPLE_W-1:0]  dvs_q;
	logic [DIV_STEPS-1:0] quot_q;
	logic [SAMPLE_W:0]    rem2;
	logic [SAMPLE_W:0]    diff;
	logic                 ge;

	always_comb begin
		rem2 = {rem_q, 1'b0};
		ge   = rem2 >= {1'b0, dvs_q};
		diff = rem2 - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= DIV_CNT_W'(DIV_STEPS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - DIV_CNT_W'(1);
			if (cnt_q == DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= req.dividend;
			dvs_q  <= req.divisor;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= ge ? diff[SAMPLE_W-1:0] : rem2[SAMPLE_W-1:0];
			quot_q <= {quot_q[DIV_STEPS-2:0], ge};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quot_q;

endmodule

// ===== sv/lookahead_peak_limiter.sv =====
// Stereo lookahead peak limiter. A frame goes ST_CHK, ST_DIV if reduction is needed
// (16-step divider computes ceiling/peak), ST_GAIN to ST_CLPR, then ST_EMIT, which
// registers the result. The shared multiplier serves release, left, right in turn.
// Input is taken only in ST_IDLE, so a waiting result that holds the next one in
// ST_EMIT blocks input. Asynchronous active-low reset: gain unity, pointer zero, ring
// reads as zero until each entry is first written (wrap flag), registers at defaults.
module lookahead_peak_limiter import lpl_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	lpl_frame_if.sink          frame,
	lpl_result_if.source       result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_CHK  = 9'b000000010,
		ST_DIV  = 9'b000000100,
		ST_GAIN = 9'b000001000,
		ST_UPD  = 9'b000010000,
		ST_MULL = 9'b000100000,
		ST_MULR = 9'b001000000,
		ST_CLPR = 9'b010000000,
		ST_EMIT = 9'b100000000
	} state_t;

	lpl_cfg_t     cfg;
	lpl_mem_req_t mem_req;
	lpl_div_req_t div_req;
	lpl_div_rsp_t div_rsp;
	logic [MEM_W-1:0] rdata;

	state_t              st_q;
	logic [ADDR_W-1:0]   wp_q;
	logic                wrapped_q;
	logic [GAIN_W-1:0]   gain_q;
	logic [GAIN_W-1:0]   req_q;
	logic [SAMPLE_W-1:0] ceil_q;
	logic [SAMPLE_W-1:0] peak_q;
	logic                rd_ok_q;
	logic signed [PROD_W-1:0]   prod_q;
	logic signed [SAMPLE_W-1:0] outl_q;
	logic signed [SAMPLE_W-1:0] outr_q;
	logic                out_valid_q;
	lpl_out_t            out_q;

	logic                acc;
	logic                lim;
	logic [LEN_W-1:0]    len_eff;
	logic [ADDR_W-1:0]   rp;
	logic [SAMPLE_W-1:0] abs_l;
	logic [SAMPLE_W-1:0] abs_r;
	logic [SAMPLE_W-1:0] peak_in;
	logic [SAMPLE_W-1:0] ceil_in;
	logic signed [SAMPLE_W-1:0] dl;
	logic signed [SAMPLE_W-1:0] dr;
	logic signed [SAMPLE_W:0]   mul_a;
	logic signed [GAIN_W:0]     mul_b;
	logic signed [PROD_W-1:0]   mul_p;
	logic [GAIN_W-1:0]   inv_c;
	logic [32:0]         relax_num;
	logic [32:0]         relax_sum;
	logic [GAIN_W-1:0]   relax_g;
	logic                out_free;

	function automatic logic [SAMPLE_W-1:0] abs24(input logic signed [SAMPLE_W-1:0] s);
		logic [SAMPLE_W:0] neg;
		neg = -{s[SAMPLE_W-1], s};
		return s[SAMPLE_W-1] ? neg[SAMPLE_W-1:0] : s;
	endfunction

	lpl_regs u_regs (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.cfg
	);

	lpl_dmem u_dmem (.clk, .req(mem_req), .rdata);

	lpl_div u_div (.clk, .arst_n, .req(div_req), .rsp(div_rsp));

	assign frame.ready = (st_q == ST_IDLE);
	assign acc         = frame.valid && frame.ready;

	// Lookahead of zero acts as one; the 8-bit length never reaches the ring depth.
	assign len_eff = (cfg.length == '0) ? LEN_W'(1) : cfg.length;
	assign rp      = wp_q - ADDR_W'(len_eff);

	assign abs_l   = abs24(frame.data.sample_left);
	assign abs_r   = abs24(frame.data.sample_right);
	assign peak_in = (abs_r > abs_l) ? abs_r : abs_l;
	assign ceil_in = (frame.data.ceiling_level > FULL_SCALE) ? FULL_SCALE
	                                                        : frame.data.ceiling_level;

	always_comb begin
		mem_req.we    = acc;
		mem_req.waddr = wp_q;
		mem_req.wdata = {frame.data.sample_right, frame.data.sample_left};
		mem_req.re    = acc;
		mem_req.raddr = rp;
	end

	assign lim              = cfg.enable && (peak_q > ceil_q);
	assign div_req.start    = (st_q == ST_CHK) && lim;
	assign div_req.dividend = ceil_q;
	assign div_req.divisor  = peak_q;

	// never-written entries read as zero
	assign dl = rd_ok_q ? $signed(rdata[SAMPLE_W-1:0]) : '0;
	assign dr = rd_ok_q ? $signed(rdata[MEM_W-1:SAMPLE_W]) : '0;

	// one shared multiplier: release term, then left, then right
	always_comb begin
		mul_b = $signed({1'b0, gain_q});
		case (st_q)
			ST_GAIN: mul_a = $signed({{(SAMPLE_W+1-COEFF_W){1'b0}}, cfg.coeff});
			ST_MULL: mul_a = {dl[SAMPLE_W-1], dl};
			ST_MULR: mul_a = {dr[SAMPLE_W-1], dr};
			default: mul_a = '0;
		endcase
		mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
	end

	// relax toward unity, rounding up
	always_comb begin
		inv_c     = UNITY_GAIN - {1'b0, cfg.coeff};
		relax_num = prod_q[32:0] + {inv_c, 16'b0};
		relax_sum = relax_num + 33'd65535;
		relax_g   = (relax_sum[32:16] > UNITY_GAIN) ? UNITY_GAIN : relax_sum[32:16];
	end

	assign out_free = !out_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			wp_q        <= '0;
			wrapped_q   <= 1'b0;
			gain_q      <= UNITY_GAIN;
			out_valid_q <= 1'b0;
		end else begin
			if (st_q == ST_EMIT && out_free)
				out_valid_q <= 1'b1;
			else if (result.ready)
				out_valid_q <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (acc) begin
						wp_q <= wp_q + ADDR_W'(1);
						if (wp_q == ADDR_W'(DELAY_DEPTH - 1))
							wrapped_q <= 1'b1;
						st_q <= ST_CHK;
					end
				end
				ST_CHK:  st_q <= lim ? ST_DIV : ST_GAIN;
				ST_DIV: begin
					if (div_rsp.done)
						st_q <= ST_GAIN;
				end
				ST_GAIN: st_q <= ST_UPD;
				ST_UPD: begin
					gain_q <= (req_q < gain_q) ? req_q : relax_g;
					st_q   <= ST_MULL;
				end
				ST_MULL: st_q <= ST_MULR;
				ST_MULR: st_q <= ST_CLPR;
				ST_CLPR: st_q <= ST_EMIT;
				ST_EMIT: begin
					if (out_free)
						st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			ceil_q  <= ceil_in;
			peak_q  <= peak_in;
			rd_ok_q <= wrapped_q || (rp < wp_q);
		end
		if (st_q == ST_CHK && !lim)
			req_q <= UNITY_GAIN;
		if (st_q == ST_DIV && div_rsp.done)
			req_q <= {1'b0, div_rsp.quotient};
		if (st_q == ST_GAIN || st_q == ST_MULL || st_q == ST_MULR)
			prod_q <= mul_p;
		if (st_q == ST_MULR)
			outl_q <= scale_clamp(prod_q, ceil_q);
		if (st_q == ST_CLPR)
			outr_q <= scale_clamp(prod_q, ceil_q);
		if (st_q == ST_EMIT && out_free) begin
			out_q.out_left     <= outl_q;
			out_q.out_right    <= outr_q;
			out_q.applied_gain <= gain_q;
		end
	end

	assign result.valid = out_valid_q;
	assign result.data  = out_q;

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> st_q == ST_DIV)
		else $error("divider finished outside the divide state");

	a_gain_le_unity: assert property (@(posedge clk) disable iff (!arst_n)
		gain_q <= UNITY_GAIN)
		else $error("running gain above unity");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> !frame.ready)
		else $error("input ready right after a frame was taken");

	a_read_not_write: assert property (@(posedge clk) disable iff (!arst_n)
		acc |-> rp != wp_q)
		else $error("delay read and write address collide");

	a_emit_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_EMIT && out_valid_q && !result.ready) |=>
		(st_q == ST_EMIT && out_valid_q))
		else $error("result word overwritten while output stalled");

endmodule

// ===== tb/lpl_checker.sv =====
// Checker for the lookahead peak limiter: tracks register writes, predicts every
// result word from the accepted frame words and compares field by field.
// Depends on lpl_pkg and the two channel interfaces.
module lpl_checker import lpl_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	lpl_frame_if               frame,
	lpl_result_if              result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic               pready,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output int                 failures,
	output int                 outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	logic                cfg_enable;
	logic [COEFF_W-1:0]  cfg_coeff;
	logic [LEN_W-1:0]    cfg_length;

	logic [SAMPLE_W-1:0] ring_l [DELAY_DEPTH];
	logic [SAMPLE_W-1:0] ring_r [DELAY_DEPTH];
	logic [ADDR_W-1:0]   wr_ptr;
	logic [GAIN_W-1:0]   gain_now;

	lpl_out_t            limited_frames[$];

	// Q1.16 gain, round half up, clamp to +/- ceiling then to 24 bits.
	function automatic logic [SAMPLE_W-1:0] apply_gain(logic [SAMPLE_W-1:0] s,
		longint g, longint ceil_v);
		longint r;
		r = (longint'($signed(s)) * g + 32768) >>> 16;
		if (r > ceil_v)
			r = ceil_v;
		if (r < -ceil_v)
			r = -ceil_v;
		if (r > 8388607)
			r = 8388607;
		if (r < -8388608)
			r = -8388608;
		return r[SAMPLE_W-1:0];
	endfunction

	function automatic lpl_out_t limit_frame(lpl_in_t w);
		longint            left;
		longint            right;
		longint            ceil_v;
		longint            peak;
		longint            req;
		longint            relax;
		logic [LEN_W-1:0]  span;
		logic [ADDR_W-1:0] rd_ptr;
		lpl_out_t          o;
		left   = longint'($signed(w.sample_left));
		right  = longint'($signed(w.sample_right));
		ceil_v = longint'(w.ceiling_level);
		if (ceil_v > longint'(FULL_SCALE))
			ceil_v = longint'(FULL_SCALE);

		ring_l[wr_ptr] = w.sample_left;
		ring_r[wr_ptr] = w.sample_right;

		peak = (left < 0) ? -left : left;
		if (right < 0)
			right = -right;
		if (right > peak)
			peak = right;

		if (cfg_enable && peak > ceil_v)
			req = (ceil_v << 16) / peak;
		else
			req = 65536;

		// attack is instant, release rounds up toward unity
		if (req < longint'(gain_now)) begin
			gain_now = GAIN_W'(req);
		end else begin
			relax = longint'(cfg_coeff) * longint'(gain_now)
				+ (65536 - longint'(cfg_coeff)) * 65536;
			relax = (relax + 65535) >>> 16;
			gain_now = (relax > 65536) ? UNITY_GAIN : GAIN_W'(relax);
		end

		span   = (cfg_length == '0) ? LEN_W'(1) : cfg_length;
		rd_ptr = wr_ptr - ADDR_W'(span);

		o.out_left     = apply_gain(ring_l[rd_ptr], longint'(gain_now), ceil_v);
		o.out_right    = apply_gain(ring_r[rd_ptr], longint'(gain_now), ceil_v);
		o.applied_gain = gain_now;
		wr_ptr = wr_ptr + 1'b1;
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		lpl_out_t want;
		if (!arst_n) begin
			cfg_enable  = RST_ENABLE;
			cfg_coeff   = RST_COEFF;
			cfg_length  = RST_LENGTH;
			ring_l      = '{default: '0};
			ring_r      = '{default: '0};
			wr_ptr      = '0;
			gain_now    = UNITY_GAIN;
			failures    = 0;
			outstanding = 0;
			limited_frames.delete();
		end else begin
			if (result.valid && result.ready) begin
				if (limited_frames.size() == 0) begin
					$error("result word with nothing expected: out_left %0d, out_right %0d, gain %0d",
						$signed(result.data.out_left), $signed(result.data.out_right),
						result.data.applied_gain);
					failures++;
				end else begin
					want = limited_frames.pop_front();
					if (result.data.out_left !== want.out_left) begin
						$error("out_left: expected %0d, got %0d",
							$signed(want.out_left), $signed(result.data.out_left));
						failures++;
					end
					if (result.data.out_right !== want.out_right) begin
						$error("out_right: expected %0d, got %0d",
							$signed(want.out_right), $signed(result.data.out_right));
						failures++;
					end
					if (result.data.applied_gain !== want.applied_gain) begin
						$error("applied_gain: expected %0d, got %0d",
							want.applied_gain, result.data.applied_gain);
						failures++;
					end
				end
			end
			if (frame.valid && frame.ready)
				limited_frames.push_back(limit_frame(frame.data));
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[PADDR_W-1:2]))
					REG_ENABLE: cfg_enable = pwdata[0];
					REG_COEFF:  cfg_coeff  = pwdata[COEFF_W-1:0];
					REG_LENGTH: cfg_length = pwdata[LEN_W-1:0];
					default: ;
				endcase
			end
			outstanding = limited_frames.size();
		end
	end

endmodule

// ===== tb/testbench.sv =====
// Top of the limiter testbench: clock, reset, register writes, frame stimulus
// with bursty sender and stalling receiver, watchdog and verdict.
// Depends on lpl_pkg, the channel interfaces, lookahead_peak_limiter and lpl_checker.
module testbench import lpl_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 40;

	typedef enum int {
		RX_OPEN,
		RX_COIN,
		RX_SPARSE,
		RX_MOSTLY
	} rx_mode_t;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	int                 failures;
	int                 outstanding;
	int                 quiet_cycles = 0;

	lpl_frame_if  frame_ch ();
	lpl_result_if result_ch ();

	lookahead_peak_limiter uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.frame   (frame_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	lpl_checker limiter_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame       (frame_ch),
		.result      (result_ch),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.failures    (failures),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if ((frame_ch.valid && frame_ch.ready) || (result_ch.valid && result_ch.ready)
			|| (psel && penable && pwrite && pready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT)
			@(negedge clk);
		$display("Mismatches found");
		$finish;
	end

	// receiver: ready pattern switches among four random modes, each held for a random span
	initial begin
		rx_mode_t mode;
		int       span;
		result_ch.ready = 1'b0;
		forever begin
			mode = rx_mode_t'($urandom_range(0, 3));
			span = $urandom_range(10, 80);
			repeat (span) begin
				@(negedge clk);
				case (mode)
					RX_OPEN:   result_ch.ready = 1'b1;
					RX_COIN:   result_ch.ready = 1'($urandom_range(0, 1));
					RX_SPARSE: result_ch.ready = ($urandom_range(0, 7) == 0);
					default:   result_ch.ready = ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	function automatic lpl_in_t frame_of(int l, int r, int c);
		return '{SAMPLE_W'(l), SAMPLE_W'(r), SAMPLE_W'(c)};
	endfunction

	function automatic logic [SAMPLE_W-1:0] random_sample();
		logic [SAMPLE_W-1:0] mag;
		case ($urandom_range(0, 9))
			0, 1: return SAMPLE_W'($urandom);
			2: begin
				case ($urandom_range(0, 3))
					0:       return 24'h800000;
					1:       return 24'h7FFFFF;
					2:       return '0;
					default: return '1;
				endcase
			end
			3, 4, 5: mag = SAMPLE_W'($urandom_range(0, 65535));
			default: mag = SAMPLE_W'($urandom_range(4000000, 8388607));
		endcase
		return $urandom_range(0, 1) ? -mag : mag;
	endfunction

	function automatic logic [SAMPLE_W-1:0] random_ceiling();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return FULL_SCALE;
			2, 3:    return SAMPLE_W'($urandom);
			4:       return SAMPLE_W'($urandom_range(0, 65535));
			default: return SAMPLE_W'($urandom_range(2000000, 8388608));
		endcase
	endfunction

	// called at a falling edge; returns at the falling edge after the word is taken
	task automatic send_frame(lpl_in_t w);
		frame_ch.valid = 1'b1;
		frame_ch.data  = w;
		do @(posedge clk); while (!frame_ch.ready);
		@(negedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [PDATA_W-1:0] value);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 2'b00};
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	task automatic wait_drained();
		frame_ch.valid = 1'b0;
		while (outstanding != 0)
			@(negedge clk);
	endtask

	task automatic configure(logic en, logic [COEFF_W-1:0] coeff, logic [LEN_W-1:0] len);
		wait_drained();
		write_reg(REG_ENABLE, PDATA_W'(en));
		write_reg(REG_COEFF, PDATA_W'(coeff));
		write_reg(REG_LENGTH, PDATA_W'(len));
	endtask

	task automatic play_random(int count, int hold_at);
		int burst;
		int gap;
		burst = 0;
		for (int i = 0; i < count; i++) begin
			if (i == hold_at) begin
				wait_drained();
				@(negedge clk);
			end
			if (burst == 0) begin
				burst = $urandom_range(1, 24);
				gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				if (gap > 0) begin
					frame_ch.valid = 1'b0;
					repeat (gap) @(negedge clk);
				end
			end
			burst--;
			send_frame('{random_sample(), random_sample(), random_ceiling()});
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		frame_ch.valid = 1'b0;
		frame_ch.data  = '0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// register defaults: long lookahead, output starts from the cleared ring
		play_random(120, -1);

		// instant release and one-frame delay so each word shows the one before
		configure(1'b1, '0, LEN_W'(1));
		send_frame(frame_of(0, 0, 8388608));
		send_frame(frame_of(8388607, -8388608, 8388608));
		send_frame(frame_of(-8388608, 8388607, 8388607));
		send_frame(frame_of(8388607, 8388607, 24'hFFFFFF));   // ceiling saturates
		send_frame(frame_of(100, -100, 0));                   // zero ceiling, gain 0
		send_frame(frame_of(0, 0, 0));
		send_frame(frame_of(4000000, -4000000, 4000000));     // peak equals ceiling
		send_frame(frame_of(-8388608, -8388608, 4194304));
		send_frame(frame_of(8388607, 0, 8388608));
		send_frame(frame_of(-1, 1, 1));
		send_frame(frame_of(1, -1, 0));
		send_frame(frame_of(1, -3, 8388608));
		send_frame(frame_of(-8388608, 0, 4194304));           // half gain: rounding halves
		send_frame(frame_of(3, -1, 8388608));
		send_frame(frame_of(-7, 7, 65536));

		configure(1'b1, 16'hFFFF, 8'hFF);
		play_random(150, -1);
		configure(1'b0, COEFF_W'(40000), LEN_W'(3));
		play_random(120, -1);
		// zero lookahead acts as one; sender holds off mid-run until drained
		configure(1'b1, RST_COEFF, '0);
		play_random(120, 60);
		repeat (3) begin
			configure(1'b1, COEFF_W'($urandom_range(0, 65535)), LEN_W'($urandom_range(1, 255)));
			play_random(110, -1);
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (failures == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== lookahead_peak_limiter.f =====
sv/lpl_pkg.sv
sv/lpl_frame_if.sv
sv/lpl_result_if.sv
sv/lpl_regs.sv
sv/lpl_dmem.sv
sv/lpl_div.sv
sv/lookahead_peak_limiter.sv
tb/lpl_checker.sv
tb/testbench.sv
